// File: rtl/core/ppmd_pkg.sv
// ---------------------------------------------------------------------------
// ppmd_pkg
// Shared types and constants of the streaming PPM pixel decoder.
// ---------------------------------------------------------------------------
package ppmd_pkg;

   // largest accepted image width or height
   localparam int MaxDim = 4096;

   // result kinds
   localparam logic [1:0] KindPixel  = 2'd0;
   localparam logic [1:0] KindHeader = 2'd1;
   localparam logic [1:0] KindError  = 2'd2;

   // error codes
   localparam logic [2:0] ErrNone      = 3'd0;
   localparam logic [2:0] ErrBadMagic  = 3'd1;
   localparam logic [2:0] ErrMaxval    = 3'd2;
   localparam logic [2:0] ErrSize      = 3'd3;
   localparam logic [2:0] ErrEarlyEnd  = 3'd4;

   // configuration register indexes
   localparam logic RegXOrigin = 1'b0;
   localparam logic RegYOrigin = 1'b1;

   // file characters
   localparam logic [7:0] ChP       = 8'h50;
   localparam logic [7:0] ChThree   = 8'h33;
   localparam logic [7:0] ChSix     = 8'h36;
   localparam logic [7:0] ChHash    = 8'h23;
   localparam logic [7:0] ChNewline = 8'h0A;
   localparam logic [7:0] ChZero    = 8'h30;
   localparam logic [7:0] ChNine    = 8'h39;

   // one result transaction
   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [12:0] column;
      logic [12:0] row;
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic [7:0]  max_value;
      logic        binary_mode;
      logic [2:0]  error_code;
      logic        last;
   } rsp_type;

   // configured origin
   typedef struct packed {
      logic [11:0] x_origin;
      logic [11:0] y_origin;
   } origin_type;

endpackage

// File: rtl/core/ppmd_csr.sv
// ---------------------------------------------------------------------------
// ppmd_csr
// Register port holding the pixel coordinate origin.
// ---------------------------------------------------------------------------
module ppmd_csr
   import ppmd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output origin_type  origin
);

   logic [11:0] x_origin_ff, x_origin_in;
   logic [11:0] y_origin_ff, y_origin_in;
   logic        wr_en;
   logic        reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   // register writes
   always_comb begin
      x_origin_in = x_origin_ff;
      y_origin_in = y_origin_ff;
      if (wr_en) begin
         unique case (reg_sel)
            RegXOrigin: x_origin_in = csr_pwdata[11:0];
            RegYOrigin: y_origin_in = csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_origin_ff <= '0;
         y_origin_ff <= '0;
      end else begin
         x_origin_ff <= x_origin_in;
         y_origin_ff <= y_origin_in;
      end
   end

   // read back
   always_comb begin
      unique case (reg_sel)
         RegXOrigin: csr_prdata = {20'd0, x_origin_ff};
         RegYOrigin: csr_prdata = {20'd0, y_origin_ff};
         default:    csr_prdata = '0;
      endcase
   end

   assign origin.x_origin = x_origin_ff;
   assign origin.y_origin = y_origin_ff;

endmodule

// File: rtl/core/ppmd_parser.sv
// ---------------------------------------------------------------------------
// ppmd_parser
// Byte parser state and the combinational decode of one input byte.
// ---------------------------------------------------------------------------
module ppmd_parser
   import ppmd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       go,
   input  logic [7:0] byte_value,
   input  logic       end_of_stream,
   input  origin_type origin,
   output logic       res_valid,
   output rsp_type    res
);

   // parse phases
   localparam logic [2:0] PhMagicP = 3'd0;
   localparam logic [2:0] PhMagicD = 3'd1;
   localparam logic [2:0] PhWidth  = 3'd2;
   localparam logic [2:0] PhHeight = 3'd3;
   localparam logic [2:0] PhMaxval = 3'd4;
   localparam logic [2:0] PhPixels = 3'd5;
   localparam logic [2:0] PhDone   = 3'd6;
   localparam logic [2:0] PhHalt   = 3'd7;

   typedef struct packed {
      logic [2:0]  phase;
      logic [15:0] acc;
      logic        active;
      logic        in_comment;
      logic        binary;
      logic [12:0] width;
      logic [12:0] height;
      logic [1:0]  comp;
      logic [7:0]  red_hold;
      logic [7:0]  green_hold;
      logic [11:0] col;
      logic [11:0] row;
   } parse_state_type;

   typedef struct packed {
      parse_state_type st;
      logic            vld;
      rsp_type         rsp;
   } step_type;

   parse_state_type state_ff, state_in;

   // error result, parser halts
   function automatic step_type emit_error(parse_state_type s, logic [2:0] code);
      step_type r;
      r                = '0;
      r.st             = s;
      r.st.phase       = PhHalt;
      r.vld            = 1'b1;
      r.rsp.result_kind = KindError;
      r.rsp.error_code = code;
      return r;
   endfunction

   // pixel result and raster advance
   function automatic step_type emit_pixel(parse_state_type s, logic [7:0] blue,
                                           origin_type org);
      step_type    r;
      logic [12:0] col_nxt;
      logic [12:0] row_nxt;
      logic        row_end;
      logic        last;
      r       = '0;
      col_nxt = {1'b0, s.col} + 13'd1;
      row_nxt = {1'b0, s.row} + 13'd1;
      row_end = col_nxt >= s.width;
      last    = row_end && (row_nxt >= s.height);
      r.vld              = 1'b1;
      r.rsp.result_kind  = KindPixel;
      r.rsp.red          = s.red_hold;
      r.rsp.green        = s.green_hold;
      r.rsp.blue         = blue;
      r.rsp.column       = {1'b0, s.col} + {1'b0, org.x_origin};
      r.rsp.row          = {1'b0, s.row} + {1'b0, org.y_origin};
      r.rsp.binary_mode  = s.binary;
      r.rsp.last         = last;
      r.st               = s;
      r.st.comp          = 2'd0;
      if (last) begin
         r.st.phase = PhDone;
      end else if (row_end) begin
         r.st.col = '0;
         r.st.row = row_nxt[11:0];
      end else begin
         r.st.col = col_nxt[11:0];
      end
      return r;
   endfunction

   // collect one color sample
   function automatic step_type take_sample(parse_state_type s, logic [7:0] smp,
                                            origin_type org);
      step_type r;
      r    = '0;
      r.st = s;
      unique case (s.comp)
         2'd0: begin
            r.st.red_hold = smp;
            r.st.comp     = 2'd1;
         end
         2'd1: begin
            r.st.green_hold = smp;
            r.st.comp       = 2'd2;
         end
         default: r = emit_pixel(s, smp, org);
      endcase
      return r;
   endfunction

   // finish the pending decimal number
   function automatic step_type take_number(parse_state_type s, origin_type org);
      step_type    r;
      logic [15:0] v;
      r        = '0;
      v        = s.acc;
      s.acc    = '0;
      s.active = 1'b0;
      r.st     = s;
      unique case (s.phase)
         PhWidth: begin
            if (v > 16'(MaxDim)) begin
               r = emit_error(s, ErrSize);
            end else begin
               r.st.width = v[12:0];
               r.st.phase = PhHeight;
            end
         end
         PhHeight: begin
            if (v > 16'(MaxDim)) begin
               r = emit_error(s, ErrSize);
            end else begin
               r.st.height = v[12:0];
               r.st.phase  = PhMaxval;
            end
         end
         PhMaxval: begin
            if (v > 16'd255) begin
               r = emit_error(s, ErrMaxval);
            end else begin
               r.vld              = 1'b1;
               r.rsp.result_kind  = KindHeader;
               r.rsp.image_width  = s.width;
               r.rsp.image_height = s.height;
               r.rsp.max_value    = v[7:0];
               r.rsp.binary_mode  = s.binary;
               r.st.col           = '0;
               r.st.row           = '0;
               r.st.comp          = 2'd0;
               if (s.width == '0 || s.height == '0) begin
                  r.rsp.last = 1'b1;
                  r.st.phase = PhDone;
               end else begin
                  r.st.phase = PhPixels;
               end
            end
         end
         PhPixels: begin
            r = take_sample(s, (v > 16'd255) ? 8'hFF : v[7:0], org);
         end
         default: ;
      endcase
      return r;
   endfunction

   // text byte: digits, separators and comments
   function automatic step_type ascii_byte(parse_state_type s, logic [7:0] b,
                                           origin_type org);
      step_type    r;
      logic [19:0] acc_x10;
      logic [2:0]  old_phase;
      r         = '0;
      r.st      = s;
      old_phase = s.phase;
      acc_x10   = ({4'd0, s.acc} << 3) + ({4'd0, s.acc} << 1) + 20'(b - ChZero);
      if (s.in_comment) begin
         if (b == ChNewline) r.st.in_comment = 1'b0;
      end else if (b >= ChZero && b <= ChNine) begin
         r.st.acc    = (acc_x10[19:16] != 4'd0) ? 16'hFFFF : acc_x10[15:0];
         r.st.active = 1'b1;
      end else begin
         if (s.active) r = take_number(s, org);
         if (!(s.active && s.binary && old_phase == PhMaxval)) begin
            if (b == ChHash && r.st.phase != PhDone && r.st.phase != PhHalt)
               r.st.in_comment = 1'b1;
         end
      end
      return r;
   endfunction

   // end of file handling
   function automatic step_type end_stream(parse_state_type s, origin_type org);
      step_type r;
      step_type tn;
      r  = '0;
      tn = '0;
      if (s.phase == PhMagicP || s.phase == PhDone || s.phase == PhHalt) begin
         r.vld = 1'b0;
      end else begin
         if (s.phase != PhMagicD && !(s.phase == PhPixels && s.binary) && s.active)
            tn = take_number(s, org);
         if (tn.vld && (tn.st.phase == PhDone || tn.st.phase == PhHalt))
            r = tn;
         else
            r = emit_error(s, ErrEarlyEnd);
      end
      r.st = '0;
      return r;
   endfunction

   // decode of the byte in the input register
   always_comb begin
      step_type r;
      r    = '0;
      r.st = state_ff;
      if (end_of_stream) begin
         r = end_stream(state_ff, origin);
      end else begin
         unique case (state_ff.phase)
            PhMagicP: begin
               if (byte_value != ChP) r = emit_error(state_ff, ErrBadMagic);
               else                   r.st.phase = PhMagicD;
            end
            PhMagicD: begin
               if (byte_value == ChThree) begin
                  r.st.binary = 1'b0;
                  r.st.phase  = PhWidth;
               end else if (byte_value == ChSix) begin
                  r.st.binary = 1'b1;
                  r.st.phase  = PhWidth;
               end else begin
                  r = emit_error(state_ff, ErrBadMagic);
               end
            end
            PhWidth, PhHeight, PhMaxval: r = ascii_byte(state_ff, byte_value, origin);
            PhPixels: begin
               if (state_ff.binary) r = take_sample(state_ff, byte_value, origin);
               else                 r = ascii_byte(state_ff, byte_value, origin);
            end
            default: ;
         endcase
      end
      state_in  = go ? r.st : state_ff;
      res_valid = go & r.vld;
      res       = r.rsp;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= '0;
      else       state_ff <= state_in;
   end

endmodule

// File: rtl/core/ppm_stream_pixel_decoder.sv
// ---------------------------------------------------------------------------
// ppm_stream_pixel_decoder
// Streaming P3/P6 image decoder: file bytes in, header and pixels out.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   req_    | in        | valid / stall      | one file byte, end of stream
//   rsp_    | out       | valid / stall      | pixel, header or error
//   csr_    | in        | apb-style, 0 wait  | x_origin @0, y_origin @4
//
// one byte per cycle sustained while rsp_ is not stalled; a byte is decoded
// while it sits in the input register and its result is loaded into the
// output register when that byte advances.
// reset clears the parser and the origin.
// a stalled output holds the input register, which then stalls req_.
// ---------------------------------------------------------------------------
module ppm_stream_pixel_decoder
   import ppmd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input bytes
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_value,
   input  logic        req_end_of_stream,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [12:0] rsp_column,
   output logic [12:0] rsp_row,
   output logic [12:0] rsp_image_width,
   output logic [12:0] rsp_image_height,
   output logic [7:0]  rsp_max_value,
   output logic        rsp_binary_mode,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       in_eos_ff;
   logic       rsp_vld_ff, rsp_vld_in;
   rsp_type    rsp_ff;
   logic       advance;
   logic       req_take;
   logic       go;
   logic       res_valid;
   rsp_type    res;
   origin_type origin;

   // configuration registers
   ppmd_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .origin     (origin)
   );

   // pipeline control
   assign advance   = !rsp_vld_ff || !rsp_stall;
   assign go        = in_vld_ff && advance;
   assign req_stall = in_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take)     in_vld_in = 1'b1;
      else if (advance) in_vld_in = 1'b0;
      else              in_vld_in = in_vld_ff;
   end

   assign rsp_vld_in = advance ? res_valid : rsp_vld_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) in_vld_ff <= 1'b0;
      else       in_vld_ff <= in_vld_in;
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_byte_value;
         in_eos_ff  <= req_end_of_stream;
      end
   end

   // byte decode
   ppmd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .go           (go),
      .byte_value   (in_byte_ff),
      .end_of_stream(in_eos_ff),
      .origin       (origin),
      .res_valid    (res_valid),
      .res          (res)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_vld_ff <= 1'b0;
      else       rsp_vld_ff <= rsp_vld_in;
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) rsp_ff <= res;
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_result_kind  = rsp_ff.result_kind;
   assign rsp_red          = rsp_ff.red;
   assign rsp_green        = rsp_ff.green;
   assign rsp_blue         = rsp_ff.blue;
   assign rsp_column       = rsp_ff.column;
   assign rsp_row          = rsp_ff.row;
   assign rsp_image_width  = rsp_ff.image_width;
   assign rsp_image_height = rsp_ff.image_height;
   assign rsp_max_value    = rsp_ff.max_value;
   assign rsp_binary_mode  = rsp_ff.binary_mode;
   assign rsp_error_code   = rsp_ff.error_code;
   assign rsp_last         = rsp_ff.last;

   // a byte held behind a stalled output keeps its value
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !advance |=> in_vld_ff && $stable(in_byte_ff) && $stable(in_eos_ff))
      else $error("input register lost a byte under stall");

   // error results carry a code and no mode bit
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.result_kind == KindError |->
         rsp_ff.error_code != ErrNone && !rsp_ff.binary_mode)
      else $error("error result without code");

   // pixels and headers carry no error code
   a_no_code: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.result_kind != KindError |-> rsp_ff.error_code == ErrNone)
      else $error("non-error result with code");

   // a header marked last belongs to an empty image
   a_empty_hdr: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.result_kind == KindHeader && rsp_ff.last |->
         rsp_ff.image_width == '0 || rsp_ff.image_height == '0)
      else $error("last header on non-empty image");

endmodule
